/* rtl/core/alpha_composite_pixel_unit_defines.svh */
// assertion macros for the alpha composite pixel unit
// expects clk and arst_n in the scope of each use
`ifndef ALPHA_COMPOSITE_PIXEL_UNIT_DEFINES_SVH
`define ALPHA_COMPOSITE_PIXEL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ACPU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acpu check failed");
`define ACPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acpu check failed");
`else
`define ACPU_ASSERT_NOW(lbl, ante, cons)
`define ACPU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/acpu_pkg.sv */
// shared types and constants of the alpha composite pixel unit
// no dependencies
`default_nettype none
package acpu_pkg;
	localparam int CH_W = 8;
	localparam int Q_W = 8;
	localparam int NUM_W = 25;
	localparam int DEN_W = 17;
	localparam int CFG_W = 3;

	// configuration register indexes
	localparam logic REG_SRC_CH = 1'b0;
	localparam logic REG_DST_CH = 1'b1;

	typedef struct packed {
		logic dst_colour;
		logic dst_alpha;
		logic zero_w;
	} ctrl_t;
endpackage
`default_nettype wire

/* rtl/core/acpu_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on acpu_pkg
`default_nettype none
module acpu_div (
	input  wire logic                     clk,
	input  wire logic [acpu_pkg::Q_W-1:0] adv,
	input  wire logic [acpu_pkg::NUM_W-1:0] num,
	input  wire logic [acpu_pkg::DEN_W-1:0] den,
	output logic [acpu_pkg::Q_W-1:0]      quo
);
	import acpu_pkg::*;

	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [NUM_W-1:0] shf;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// trial subtract of the divisor at this bit weight
		assign shf = NUM_W'(den_in) << (Q_W - 1 - k);
		assign ge  = rem_in >= shf;

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k] <= ge ? rem_in - shf : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= quo_in | (ge ? Q_W'(1) << (Q_W - 1 - k) : '0);
			end
		end
	end

	assign quo = quo_s[Q_W-1];
endmodule
`default_nettype wire

/* rtl/core/alpha_composite_pixel_unit.sv */
// source-over alpha composite of one pixel onto one pixel, 12 stage pipeline
// depends on acpu_pkg, acpu_div and alpha_composite_pixel_unit_defines.svh
//
// channel  port group    payload
// in       s_axis_*      source c0..c3, destination c0..c3, 8 bits each
// out      m_axis_*      new destination c0..c3, 8 bits each
// config   cfg_*         src_channels (index 0), dst_channels (index 1)
//
// one pixel per cycle while m_axis_tready does not stall the output
// stages: convert, products, scaled terms, numerator/divisor, 8 divider bits
// each stage holds its item while the stage after it is full and cannot move, bubbles collapse
// reset clears valid bits and sets both channel counts to 4
`default_nettype none
`include "alpha_composite_pixel_unit_defines.svh"
module alpha_composite_pixel_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// src_c0, src_c1, src_c2, src_c3, dst_c0, dst_c1, dst_c2, dst_c3
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_c0, out_c1, out_c2, out_c3
	output logic [31:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [acpu_pkg::CFG_W-1:0] cfg_wdata
);
	import acpu_pkg::*;

	localparam int NST = 4 + Q_W;

	function automatic logic [2:0] clamp_ch(input logic [CFG_W-1:0] c);
		logic [2:0] r;
		r = c;
		if (c == 3'd0) r = 3'd1;
		else if (c > 3'd4) r = 3'd4;
		return r;
	endfunction

	logic [CFG_W-1:0] src_ch_q, dst_ch_q;
	logic [NST-1:0]   vld_s, adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch_q <= 3'd4;
			dst_ch_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SRC_CH: src_ch_q <= cfg_wdata;
				REG_DST_CH: dst_ch_q <= cfg_wdata;
			endcase
		end
	end

	// stage advance chain, a stage moves when empty or when the next one moves
	always_comb begin
		adv[NST-1] = !vld_s[NST-1] || m_axis_tready;
		for (int k = NST - 2; k >= 0; k--) adv[k] = !vld_s[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= s_axis_tvalid;
			for (int k = 1; k < NST; k++) if (adv[k]) vld_s[k] <= vld_s[k-1];
		end
	end

	assign s_axis_tready = adv[0];

	// source conversion into the destination model
	logic [2:0]      sc, dc;
	logic [CH_W-1:0] s [4];
	logic [CH_W-1:0] d [4];
	logic [CH_W-1:0] hi, lo, gray, sa_c, da_c;
	logic [CH_W-1:0] col_c [3];
	logic            dcol_c, dalp_c;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			s[k] = s_axis_tdata[8*k +: 8];
			d[k] = s_axis_tdata[32 + 8*k +: 8];
		end
		sc = clamp_ch(src_ch_q);
		dc = clamp_ch(dst_ch_q);
		dcol_c = dc >= 3'd3;
		dalp_c = (dc == 3'd2) || (dc == 3'd4);
		hi = s[0];
		lo = s[0];
		if (s[1] > hi) hi = s[1];
		if (s[2] > hi) hi = s[2];
		if (s[1] < lo) lo = s[1];
		if (s[2] < lo) lo = s[2];
		gray = CH_W'(({1'b0, hi} + {1'b0, lo}) >> 1);
		if (sc == 3'd2) sa_c = s[1];
		else if (sc == 3'd4) sa_c = s[3];
		else sa_c = 8'd255;
		if (dcol_c) begin
			col_c[0] = s[0];
			col_c[1] = (sc >= 3'd3) ? s[1] : s[0];
			col_c[2] = (sc >= 3'd3) ? s[2] : s[0];
		end else begin
			col_c[0] = (sc >= 3'd3) ? gray : s[0];
			col_c[1] = '0;
			col_c[2] = '0;
		end
		if (dalp_c) da_c = dcol_c ? d[3] : d[1];
		else da_c = 8'd255;
	end

	logic [CH_W-1:0] sa_s1, da_s1;
	logic [CH_W-1:0] col_s1 [3];
	logic [CH_W-1:0] dst_s1 [3];
	ctrl_t           ctl_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sa_s1  <= sa_c;
			da_s1  <= da_c;
			ctl_s1 <= '{dst_colour: dcol_c, dst_alpha: dalp_c, zero_w: 1'b0};
			for (int i = 0; i < 3; i++) begin
				col_s1[i] <= col_c[i];
				dst_s1[i] <= d[i];
			end
		end
	end

	// first products
	logic [15:0]     p1_s2 [3];
	logic [15:0]     p2_s2;
	logic [CH_W-1:0] sa_s2;
	logic [CH_W-1:0] dst_s2 [3];
	ctrl_t           ctl_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				p1_s2[i]  <= sa_s1 * col_s1[i];
				dst_s2[i] <= dst_s1[i];
			end
			p2_s2  <= ctl_s1.dst_alpha ? da_s1 * (8'd255 - sa_s1) : 16'(8'd255 - sa_s1);
			sa_s2  <= sa_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	// scaled terms and combined weight
	logic [23:0] m_s3 [3];
	logic [23:0] a_s3 [3];
	logic [15:0] w_s3;
	ctrl_t       ctl_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= p2_s2 * dst_s2[i];
				a_s3[i] <= ctl_s2.dst_alpha ? {p1_s2[i], 8'd0} - 24'(p1_s2[i])
					: 24'(p1_s2[i]);
			end
			w_s3   <= {sa_s2, 8'd0} - 16'(sa_s2) + p2_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// alpha as round-half-up of w / 255 by a reciprocal, w never exceeds 65025
	logic [15:0] ay_c, aq_c;

	assign ay_c = w_s3 + 16'd127;
	assign aq_c = ay_c + (ay_c >> 8) + 16'd1;

	// numerators and divisors with half-up rounding folded in
	logic [NUM_W-1:0] num_s4 [3];
	logic [DEN_W-1:0] den_s4 [3];
	logic [Q_W-1:0]   alp_s4;
	ctrl_t            ctl_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= {a_s3[i] + m_s3[i], 1'b0}
					+ (ctl_s3.dst_alpha ? NUM_W'(w_s3) : NUM_W'(255));
				den_s4[i] <= ctl_s3.dst_alpha ? {w_s3, 1'b0} : DEN_W'(510);
			end
			alp_s4 <= aq_c[15:8];
			ctl_s4 <= '{dst_colour: ctl_s3.dst_colour, dst_alpha: ctl_s3.dst_alpha,
				zero_w: ctl_s3.dst_alpha && (w_s3 == '0)};
		end
	end

	// divider lanes: three colour channels
	logic [Q_W-1:0] q [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		acpu_div u_div (
			.clk (clk),
			.adv (adv[NST-1:4]),
			.num (num_s4[i]),
			.den (den_s4[i]),
			.quo (q[i])
		);
	end

	ctrl_t          ctl_d_s [Q_W];
	logic [Q_W-1:0] alp_d_s [Q_W];

	// control and alpha travel beside the divider stages
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			ctl_d_s[0] <= ctl_s4;
			alp_d_s[0] <= alp_s4;
		end
		for (int k = 1; k < Q_W; k++)
			if (adv[4+k]) begin
				ctl_d_s[k] <= ctl_d_s[k-1];
				alp_d_s[k] <= alp_d_s[k-1];
			end
	end

	// place channels in the destination layout
	ctrl_t          ctl_o;
	logic [Q_W-1:0] c_o [3];
	logic [Q_W-1:0] a_o;

	always_comb begin
		ctl_o = ctl_d_s[Q_W-1];
		for (int i = 0; i < 3; i++) c_o[i] = ctl_o.zero_w ? '0 : q[i];
		a_o = ctl_o.dst_alpha ? alp_d_s[Q_W-1] : '0;
		if (ctl_o.dst_colour) m_axis_tdata = {a_o, c_o[2], c_o[1], c_o[0]};
		else m_axis_tdata = {8'd0, 8'd0, a_o, c_o[0]};
	end

	assign m_axis_tvalid = vld_s[NST-1];

	`ACPU_ASSERT_NOW(a_full_when_blocked, !s_axis_tready, &vld_s)
	`ACPU_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ACPU_ASSERT_NEXT(a_bubble_enters, s_axis_tready && !s_axis_tvalid, !vld_s[0])
endmodule
`default_nettype wire
